FILE: src/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// shared types and constants of the bmp pixel stream decoder
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int PALETTE_ENTRIES = 256;

  localparam int PAL_ADDR_W = $clog2(PALETTE_ENTRIES);
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // depth codes
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  // item kinds on in_tuser
  localparam logic ACT_PIXEL   = 1'b0;
  localparam logic ACT_PAL_WR  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN     = 8'd3;

  // palette write request
  typedef struct packed {
    logic                  en;
    logic [PAL_ADDR_W-1:0] addr;
    logic [RGB_W-1:0]      rgb;   // red:green:blue
  } pal_wr_t;

  // palette read request
  typedef struct packed {
    logic                  en;
    logic [PAL_ADDR_W-1:0] addr;
  } pal_rd_t;

endpackage

FILE: src/bmpd_palette.sv
// ----------------------------------------------------------------------------
// bmpd_palette
// palette memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmpd_palette
  import bmpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pal_wr_t          wr,
  input  pal_rd_t          rd,
  output logic [RGB_W-1:0] rd_rgb
);

  logic [RGB_W-1:0]           mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic [RGB_W-1:0]           q_r;
  logic                       hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.rgb;
    end
    if (rd.en) begin
      q_r <= mem[rd.addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        hit_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_rgb = hit_r ? q_r : '0;

endmodule

FILE: src/bmp_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// decodes a bmp pixel array byte stream into bgr888 pixels with coordinates
// ----------------------------------------------------------------------------
// The block takes one item per clock on the input stream while in_tready is
// high, pixel bytes and palette writes alike, and produces one pixel item each
// time the last byte of a pixel arrives. After its final byte is accepted, a
// pixel passes the stage 1 register, in step with the palette memory read,
// then the output register. The input stays ready while a result waits, up to
// one more finished pixel held between the palette read and the output
// register. Depths: 8 bit paletted, 16 bit 5-5-5 (channels shifted left by 3),
// 24 bit and 32 bit (fourth byte dropped). Row padding to a 4-byte boundary is
// skipped. Rows count bottom-up unless top_down is set; after the last pixel
// of an image the counters restart. Palette entries read as zero until written;
// the palette needs no clearing pass. The user must see that configuration is
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // data_byte, palette_index, palette_blue, palette_green, palette_red
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                  in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_blue, out_green, out_red, out_column, out_row
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_pixel
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WSZ = $clog2(MAX_WIDTH + 1);
  localparam int HSZ = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);

  // configuration registers
  logic [1:0]            depth_r;
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic                  top_down_r;

  // stream state
  logic [1:0]     phase_r,   phase_nxt;
  logic [15:0]    partial_r, partial_nxt;  // bytes 0 and 1; byte 2 is kept in byte2_r, 32 bit reads it
  logic [CH_W-1:0] byte2_r,  byte2_nxt;
  logic [CW-1:0]  col_r,     col_nxt;
  logic [RW-1:0]  row_r,     row_nxt;
  logic [1:0]     pad_r,     pad_nxt;

  // stage in step with the palette read
  logic                 s1_valid_r;
  logic                 s1_pal_r;
  logic [RGB_W-1:0]     s1_rgb_r;     // red:green:blue for direct modes
  logic [COORD_W-1:0]   s1_col_r;
  logic [COORD_W-1:0]   s1_row_r;
  logic                 s1_last_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  // input fields
  logic                  act;
  logic [CH_W-1:0]       data_byte;
  logic [PAL_ADDR_W-1:0] pal_index;
  logic [CH_W-1:0]       pal_blue, pal_green, pal_red;

  logic acc, pix_acc, fin_acc, s1_move;

  logic [WSZ-1:0] w;
  logic [HSZ-1:0] h;
  logic [CW-1:0]  wm1, col_sel;
  logic [RW-1:0]  hm1, row_sel, row_dst;
  logic           end_of_row, last;
  logic [1:0]     bpb2, prod2;
  logic [15:0]    packed16;
  logic [CH_W-1:0] b, g, r;
  logic [RGB_W-1:0] pal_rgb, out_rgb;

  pal_wr_t pal_wr;
  pal_rd_t pal_rd;

  assign act       = in_tuser;
  assign data_byte = in_tdata[7:0];
  assign pal_index = in_tdata[15:8];
  assign pal_blue  = in_tdata[23:16];
  assign pal_green = in_tdata[31:24];
  assign pal_red   = in_tdata[39:32];

  // ---------------------------------------------------------------- handshake
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign acc       = in_tvalid && in_tready;
  assign pix_acc   = acc && (act == ACT_PIXEL) && (pad_r == 2'd0);
  // final byte once the phase reaches the current depth's last byte
  assign fin_acc   = pix_acc && (phase_r >= depth_r);

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= DEPTH_24;
      width_r    <= CFG_DATA_W'(1);
      height_r   <= CFG_DATA_W'(1);
      top_down_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEPTH_MODE:   depth_r    <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  width_r    <= cfg_data;
        REG_IMAGE_HEIGHT: height_r   <= cfg_data;
        REG_TOP_DOWN:     top_down_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- geometry
  // zero reads as one, oversize saturates to the maximum
  always_comb begin
    if (width_r == '0) begin
      w = WSZ'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w = WSZ'(MAX_WIDTH);
    end else begin
      w = WSZ'(width_r);
    end
    if (height_r == '0) begin
      h = HSZ'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h = HSZ'(MAX_HEIGHT);
    end else begin
      h = HSZ'(height_r);
    end
  end

  assign wm1     = CW'(w - WSZ'(1));
  assign hm1     = RW'(h - HSZ'(1));
  // counters beyond a shrunk size stick to the last column or row
  assign col_sel = (WSZ'(col_r) < w) ? col_r : wm1;
  assign row_sel = (HSZ'(row_r) < h) ? row_r : hm1;
  assign end_of_row = (col_sel == wm1);
  assign last       = end_of_row && (row_sel == hm1);
  assign row_dst    = top_down_r ? row_sel : RW'(hm1 - row_sel);

  // pad bytes of a row: -(bytes per pixel * width) mod 4
  assign bpb2  = depth_r + 2'd1;
  assign prod2 = 2'(bpb2 * w[1:0]);

  // ---------------------------------------------------------------- colour
  assign packed16 = {data_byte, partial_r[7:0]};

  always_comb begin
    case (depth_r)
      DEPTH_16: begin
        b = {packed16[4:0],   3'b000};
        g = {packed16[9:5],   3'b000};
        r = {packed16[14:10], 3'b000};
      end
      DEPTH_24: begin
        b = partial_r[7:0];
        g = partial_r[15:8];
        r = data_byte;
      end
      DEPTH_32: begin
        b = partial_r[7:0];
        g = partial_r[15:8];
        r = byte2_r;
      end
      default: begin
        // paletted: colour comes from memory
        b = '0;
        g = '0;
        r = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- stream state
  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    byte2_nxt   = byte2_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    if (acc && (act == ACT_PIXEL)) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else if (!fin_acc) begin
        case (phase_r)
          2'd0:    partial_nxt[7:0]  = partial_r[7:0]  | data_byte;
          2'd1:    partial_nxt[15:8] = partial_r[15:8] | data_byte;
          2'd2:    byte2_nxt         = byte2_r         | data_byte;
          default: ;
        endcase
        phase_nxt = phase_r + 2'd1;
      end else begin
        phase_nxt   = 2'd0;
        partial_nxt = '0;
        byte2_nxt   = '0;
        if (end_of_row) begin
          col_nxt = '0;
          row_nxt = last ? '0 : RW'(row_sel + RW'(1));
          pad_nxt = 2'(2'd0 - prod2);
        end else begin
          col_nxt = CW'(col_sel + CW'(1));
          row_nxt = row_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      partial_r <= '0;
      byte2_r   <= '0;
      col_r     <= '0;
      row_r     <= '0;
      pad_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      byte2_r   <= byte2_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
    end
  end

  // ---------------------------------------------------------------- palette
  // a write lands before any later item reads, so no forwarding is needed
  assign pal_wr.en   = acc && (act == ACT_PAL_WR);
  assign pal_wr.addr = pal_index;
  assign pal_wr.rgb  = {pal_red, pal_green, pal_blue};
  assign pal_rd.en   = fin_acc && (depth_r == DEPTH_8);
  assign pal_rd.addr = data_byte;

  bmpd_palette u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd     (pal_rd),
    .rd_rgb (pal_rgb)
  );

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (fin_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_acc) begin
      s1_pal_r  <= (depth_r == DEPTH_8);
      s1_rgb_r  <= {r, g, b};
      s1_col_r  <= COORD_W'(col_sel);
      s1_row_r  <= COORD_W'(row_dst);
      s1_last_r <= last;
    end
  end

  // ---------------------------------------------------------------- output
  assign out_rgb = s1_pal_r ? pal_rgb : s1_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= {s1_row_r, s1_col_r, out_rgb[23:16], out_rgb[15:8], out_rgb[7:0]};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- checks
  // input backs off only when both result slots are full
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free result slot");

  // pad bytes are only skipped between whole pixels
  a_pad_at_pixel_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (pad_r != 2'd0) |-> (phase_r == 2'd0))
    else $error("pad pending inside a pixel");

  // the last pixel of an image restarts both counters
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_acc && last) |=> (col_r == '0 && row_r == '0))
    else $error("counters did not restart after the last pixel");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
